// ===== rtl/psfrl_pkg.sv =====
// Package for the per-source failure rate limiter.
// Holds table geometry, field widths, status codes and the record types.
// No dependencies.
package psfrl_pkg;

  localparam int TBL_ENTRIES = 64;
  localparam int IDX_W       = (TBL_ENTRIES > 1) ? $clog2(TBL_ENTRIES) : 1;

  localparam int SRC_W  = 32;
  localparam int TIME_W = 48;
  localparam int CNT_W  = 16;
  localparam int WIN_W  = 32;
  localparam int STAT_W = 2;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_COUNTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_BLOCK   = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO    = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic [CNT_W-1:0] RST_THRESHOLD = 16'd20;
  localparam logic [WIN_W-1:0] RST_WINDOW    = 32'd120000;
  localparam logic [WIN_W-1:0] RST_COOLDOWN  = 32'd120000;

  // One table entry as stored in the entry memory.
  typedef struct packed {
    logic [SRC_W-1:0]  source;
    logic [TIME_W-1:0] window_start;
    logic [CNT_W-1:0]  count;
    logic              cool_armed;
    logic [TIME_W-1:0] cool_until;
  } entry_t;

  // Verdict of the entry evaluator for one entry.
  typedef struct packed {
    logic hit;       // valid and same source
    logic spare;     // free, or reusable
    logic expired;   // window older than window_ms
    logic cool_run;  // cooldown still running
  } eval_t;

endpackage

// ===== rtl/per_source_failure_rate_limiter.sv =====
// Top level of the per-source failure rate limiter.
// Depends on psfrl_pkg and psfrl_eval.
//
// Each accepted event is looked up by a scan of the 64-entry table, one entry a cycle
// through the single read port of the entry memory, stopping at the first entry that
// holds the source. A new source or a full table scans all entries; a zero source skips
// the scan. One event is in work at a time and in_tready stays low until its result is
// loaded into the output register. Valid bits are cleared at reset, so the table is
// usable right away. Configuration writes are always taken.
module per_source_failure_rate_limiter (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: source_ip [31:0], now_ms [79:32]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [psfrl_pkg::IN_DATA_W-1:0]     in_tdata,
  // out_tdata: status [1:0], fail_count [17:2], zero [23:18]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [psfrl_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psfrl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psfrl_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import psfrl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COUNT,
    S_WRITE,
    S_RESULT
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TBL_ENTRIES - 1);

  state_t                  state_r, state_nxt;
  logic [SRC_W-1:0]        src_r, src_nxt;
  logic [TIME_W-1:0]       now_r, now_nxt;
  logic                    issue_on_r, issue_on_nxt;
  logic [IDX_W-1:0]        rd_addr_r, rd_addr_nxt;
  logic                    ev_on_r, ev_on_nxt;
  logic [IDX_W-1:0]        ev_idx_r, ev_idx_nxt;
  logic                    ev_last_r, ev_last_nxt;
  logic                    spare_found_r, spare_found_nxt;
  logic [IDX_W-1:0]        spare_idx_r, spare_idx_nxt;
  logic [IDX_W-1:0]        tgt_idx_r, tgt_idx_nxt;
  logic                    tgt_new_r, tgt_new_nxt;
  logic                    tgt_restart_r, tgt_restart_nxt;
  logic                    tgt_cool_run_r, tgt_cool_run_nxt;
  entry_t                  tgt_rec_r, tgt_rec_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    blk_r, blk_nxt;
  logic [STAT_W-1:0]       res_status_r, res_status_nxt;
  logic [CNT_W-1:0]        res_count_r, res_count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic [TBL_ENTRIES-1:0]  valid_r, valid_nxt;
  logic [CNT_W-1:0]        thresh_r, thresh_nxt;
  logic [WIN_W-1:0]        window_r, window_nxt;
  logic [WIN_W-1:0]        cooldown_r, cooldown_nxt;

  entry_t                  mem [TBL_ENTRIES];
  entry_t                  rd_data_r;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  entry_t                  mem_wdata;

  eval_t                   verdict;
  logic [CNT_W-1:0]        cnt_base;
  logic [CNT_W-1:0]        cnt_inc;
  logic [TIME_W:0]         until_sum;
  logic [TIME_W-1:0]       until_sat;
  logic                    in_xfer;
  logic                    cfg_xfer;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign cfg_xfer   = cfg_valid && cfg_ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  psfrl_eval u_eval (
    .rec       (rd_data_r),
    .rec_valid (valid_r[ev_idx_r]),
    .source    (src_r),
    .now       (now_r),
    .window_ms (window_r),
    .verdict   (verdict)
  );

  // Saturating count step and the saturating cooldown deadline.
  assign cnt_base  = tgt_restart_r ? '0 : tgt_rec_r.count;
  assign cnt_inc   = (cnt_base == CNT_MAX) ? CNT_MAX : cnt_base + 1'b1;
  assign until_sum = {1'b0, now_r} + {{(TIME_W+1-WIN_W){1'b0}}, cooldown_r};
  assign until_sat = until_sum[TIME_W] ? TIME_MAX : until_sum[TIME_W-1:0];

  always_comb begin
    state_nxt        = state_r;
    src_nxt          = src_r;
    now_nxt          = now_r;
    issue_on_nxt     = issue_on_r;
    rd_addr_nxt      = rd_addr_r;
    ev_on_nxt        = 1'b0;
    ev_idx_nxt       = ev_idx_r;
    ev_last_nxt      = ev_last_r;
    spare_found_nxt  = spare_found_r;
    spare_idx_nxt    = spare_idx_r;
    tgt_idx_nxt      = tgt_idx_r;
    tgt_new_nxt      = tgt_new_r;
    tgt_restart_nxt  = tgt_restart_r;
    tgt_cool_run_nxt = tgt_cool_run_r;
    tgt_rec_nxt      = tgt_rec_r;
    cnt_nxt          = cnt_r;
    blk_nxt          = blk_r;
    res_status_nxt   = res_status_r;
    res_count_nxt    = res_count_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_data_nxt     = out_data_r;
    valid_nxt        = valid_r;
    thresh_nxt       = thresh_r;
    window_nxt       = window_r;
    cooldown_nxt     = cooldown_r;
    mem_we           = 1'b0;
    mem_waddr        = tgt_idx_r;
    mem_wdata        = tgt_rec_r;

    if (cfg_xfer) begin
      unique case (cfg_index)
        REG_THRESHOLD: thresh_nxt   = cfg_data[CNT_W-1:0];
        REG_WINDOW:    window_nxt   = cfg_data[WIN_W-1:0];
        REG_COOLDOWN:  cooldown_nxt = cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          src_nxt         = in_tdata[SRC_W-1:0];
          now_nxt         = in_tdata[SRC_W +: TIME_W];
          rd_addr_nxt     = '0;
          issue_on_nxt    = 1'b1;
          spare_found_nxt = 1'b0;
          if (in_tdata[SRC_W-1:0] == '0) begin
            res_status_nxt = ST_ZERO;
            res_count_nxt  = '0;
            state_nxt      = S_RESULT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Read side: one entry address a cycle; the data comes back through the registered read port.
        if (issue_on_r) begin
          ev_on_nxt   = 1'b1;
          ev_idx_nxt  = rd_addr_r;
          ev_last_nxt = (rd_addr_r == LAST_IDX);
          if (rd_addr_r == LAST_IDX) begin
            issue_on_nxt = 1'b0;
          end else begin
            rd_addr_nxt = rd_addr_r + 1'b1;
          end
        end
        // Evaluate side: a match ends the scan, otherwise remember the first spare.
        if (ev_on_r) begin
          if (verdict.hit) begin
            tgt_idx_nxt      = ev_idx_r;
            tgt_new_nxt      = 1'b0;
            tgt_restart_nxt  = verdict.expired;
            tgt_cool_run_nxt = verdict.cool_run;
            tgt_rec_nxt      = rd_data_r;
            issue_on_nxt     = 1'b0;
            ev_on_nxt        = 1'b0;
            state_nxt        = S_COUNT;
          end else begin
            if (verdict.spare && !spare_found_r) begin
              spare_found_nxt = 1'b1;
              spare_idx_nxt   = ev_idx_r;
            end
            if (ev_last_r) begin
              ev_on_nxt = 1'b0;
              if (spare_found_r || verdict.spare) begin
                tgt_idx_nxt      = spare_found_r ? spare_idx_r : ev_idx_r;
                tgt_new_nxt      = 1'b1;
                tgt_restart_nxt  = 1'b1;
                tgt_cool_run_nxt = 1'b0;
                state_nxt        = S_COUNT;
              end else begin
                res_status_nxt = ST_FULL;
                res_count_nxt  = '0;
                state_nxt      = S_RESULT;
              end
            end
          end
        end
      end

      S_COUNT: begin
        cnt_nxt   = cnt_inc;
        blk_nxt   = (cnt_inc >= thresh_r) && !tgt_cool_run_r;
        state_nxt = S_WRITE;
      end

      S_WRITE: begin
        mem_we                 = 1'b1;
        mem_wdata.source       = src_r;
        mem_wdata.window_start = (tgt_restart_r || blk_r) ? now_r : tgt_rec_r.window_start;
        mem_wdata.count        = blk_r ? '0 : cnt_r;
        mem_wdata.cool_armed   = blk_r || (!tgt_new_r && tgt_rec_r.cool_armed);
        if (blk_r) begin
          mem_wdata.cool_until = until_sat;
        end else if (tgt_new_r) begin
          mem_wdata.cool_until = '0;
        end else begin
          mem_wdata.cool_until = tgt_rec_r.cool_until;
        end
        valid_nxt[tgt_idx_r] = 1'b1;
        res_status_nxt       = blk_r ? ST_BLOCK : ST_COUNTED;
        res_count_nxt        = blk_r ? '0 : cnt_r;
        state_nxt            = S_RESULT;
      end

      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_DATA_W-STAT_W-CNT_W){1'b0}}, res_count_r, res_status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      issue_on_r    <= 1'b0;
      ev_on_r       <= 1'b0;
      spare_found_r <= 1'b0;
      out_valid_r   <= 1'b0;
      valid_r       <= '0;
      thresh_r      <= RST_THRESHOLD;
      window_r      <= RST_WINDOW;
      cooldown_r    <= RST_COOLDOWN;
    end else begin
      state_r       <= state_nxt;
      issue_on_r    <= issue_on_nxt;
      ev_on_r       <= ev_on_nxt;
      spare_found_r <= spare_found_nxt;
      out_valid_r   <= out_valid_nxt;
      valid_r       <= valid_nxt;
      thresh_r      <= thresh_nxt;
      window_r      <= window_nxt;
      cooldown_r    <= cooldown_nxt;
    end
    src_r          <= src_nxt;
    now_r          <= now_nxt;
    rd_addr_r      <= rd_addr_nxt;
    ev_idx_r       <= ev_idx_nxt;
    ev_last_r      <= ev_last_nxt;
    spare_idx_r    <= spare_idx_nxt;
    tgt_idx_r      <= tgt_idx_nxt;
    tgt_new_r      <= tgt_new_nxt;
    tgt_restart_r  <= tgt_restart_nxt;
    tgt_cool_run_r <= tgt_cool_run_nxt;
    tgt_rec_r      <= tgt_rec_nxt;
    cnt_r          <= cnt_nxt;
    blk_r          <= blk_nxt;
    res_status_r   <= res_status_nxt;
    res_count_r    <= res_count_nxt;
    out_data_r     <= out_data_nxt;
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr_r];
  end

endmodule

// ===== rtl/psfrl_eval.sv =====
// Entry evaluator: the compare unit shared by every step of the table scan.
// Decides match, reuse, window expiry and cooldown for one entry.
// Depends on psfrl_pkg.
module psfrl_eval (
  input  psfrl_pkg::entry_t             rec,
  input  logic                          rec_valid,
  input  logic [psfrl_pkg::SRC_W-1:0]   source,
  input  logic [psfrl_pkg::TIME_W-1:0]  now,
  input  logic [psfrl_pkg::WIN_W-1:0]   window_ms,
  output psfrl_pkg::eval_t              verdict
);
  import psfrl_pkg::*;

  logic [TIME_W-1:0] elapsed;

  // Elapsed time wraps modulo 2^48 when the clock runs backwards.
  assign elapsed = now - rec.window_start;

  always_comb begin
    verdict.hit      = rec_valid && (rec.source == source);
    verdict.expired  = elapsed > {{(TIME_W-WIN_W){1'b0}}, window_ms};
    verdict.cool_run = rec.cool_armed && (now < rec.cool_until);
    verdict.spare    = !rec_valid || (verdict.expired && !verdict.cool_run);
  end

endmodule

// ===== rtl/psfrl_checker.sv =====
// Port-level checker for the per-source failure rate limiter, bound to the top level.
// Depends on psfrl_pkg and per_source_failure_rate_limiter.
module psfrl_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [psfrl_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import psfrl_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Only one event is in work: a transfer closes the input until its result is out.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an event is in work");

  // Block, zero-address and untracked results all report a count of zero.
  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[STAT_W-1:0] != ST_COUNTED)
      |-> out_tdata[STAT_W +: CNT_W] == '0)
    else $error("nonzero count with a non-counted status");

  // Padding bits stay zero.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:STAT_W+CNT_W] == '0)
    else $error("padding bits set in result");

endmodule

bind per_source_failure_rate_limiter psfrl_checker u_psfrl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
